// ----- sv/eavf_pkg.sv -----
package eavf_pkg;

  // field widths
  localparam int COUNT_W = 12;
  localparam int TIME_W  = 32;
  localparam int ANGLE_W = 19;
  localparam int VEL_W   = 32;
  localparam int RPM_W   = 32;
  localparam int TH_W    = 12;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd1;
  localparam logic [TH_W-1:0]      THRESHOLD_RESET = 12'd256;

  // digit-serial multiplier
  localparam int DIGIT_W   = 4;
  localparam int OPND_W    = 32;
  localparam int K_W       = 31;
  localparam int PROD_W    = 64;
  localparam int MUL_CNT_W = 4;
  localparam logic [MUL_CNT_W-1:0] ANG_DIGITS = MUL_CNT_W'(COUNT_W / DIGIT_W);
  localparam logic [MUL_CNT_W-1:0] RPM_DIGITS = MUL_CNT_W'(VEL_W / DIGIT_W);

  // pi in Q2.29 and 30/pi in Q7.24
  localparam logic [K_W-1:0] PI_Q29  = 31'd1686629713;
  localparam logic [K_W-1:0] RPM_Q24 = 31'd160210611;

  // bit-serial divider: |delta angle| * 1000 stays below 2^29
  localparam int NUM_W     = 29;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic busy;
    logic done;
  } eavf_stat_t;

endpackage

// ----- sv/eavf_mul.sv -----
module eavf_mul
  import eavf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [OPND_W-1:0]    operand,
  input  logic [K_W-1:0]       k,
  input  logic [MUL_CNT_W-1:0] digits,
  output eavf_stat_t           stat,
  output logic [PROD_W-1:0]    prod
);

  logic [OPND_W-1:0]        x;
  logic [K_W-1:0]           kreg;
  logic [MUL_CNT_W-1:0]     cnt;
  logic                     busy;
  logic                     done;
  logic [K_W+DIGIT_W-1:0]   part;
  logic [PROD_W-1:0]        prod_next;

  // msb-first: shift accumulator one digit, add digit times constant
  assign part = (K_W+DIGIT_W)'(x[OPND_W-1 -: DIGIT_W]) * (K_W+DIGIT_W)'(kreg);
  assign prod_next = {prod[PROD_W-DIGIT_W-1:0], DIGIT_W'(0)} + PROD_W'(part);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= operand;
        kreg <= k;
        prod <= '0;
        cnt  <= digits;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod_next;
        x    <= {x[OPND_W-DIGIT_W-1:0], DIGIT_W'(0)};
        cnt  <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- sv/eavf_div.sv -----
module eavf_div
  import eavf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [TIME_W-1:0] den,
  output eavf_stat_t        stat,
  output logic [NUM_W-1:0]  quo
);

  logic [TIME_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [TIME_W:0]      sh;
  logic                 ge;

  // restoring step, one quotient bit per cycle
  assign sh = {rem, quo[NUM_W-1]};
  assign ge = (sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= num;
        cnt  <= DIV_CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? TIME_W'(sh - {1'b0, den}) : sh[TIME_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- sv/encoder_angle_velocity_filter_unit.sv -----
// in_stall holds off a new word until the previous one has run the 29-step bit-serial divider
//   and the 3-digit angle and 8-digit rpm passes of the shared 4-bit multiplier
// an output word waiting on out_stall does not block the next input accept
// reset (rst, synchronous): threshold 256, positive direction, filter state,
//   previous angle, velocity and timestamp cleared, both channels empty
module encoder_angle_velocity_filter_unit
  import eavf_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [COUNT_W-1:0]           raw_count,
  input  logic [TIME_W-1:0]            time_ms,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COUNT_W-1:0]           filtered_count,
  output logic signed [ANGLE_W-1:0]    angle_rad,
  output logic signed [VEL_W-1:0]      velocity_rad_s,
  output logic signed [RPM_W-1:0]      speed_rpm,
  output logic                         glitch_flag
);

  typedef enum logic [2:0] {ST_IDLE, ST_ANG, ST_DIV, ST_RPM, ST_FIN} state_t;

  state_t state;

  // configuration registers
  logic [TH_W-1:0] jump_threshold;
  logic            direction_negative;

  // filter and estimator state
  logic [COUNT_W-1:0]       current_count;
  logic [COUNT_W-1:0]       previous_count;
  logic                     noise_seen;
  logic signed [ANGLE_W-1:0] previous_angle;
  logic signed [VEL_W-1:0]  previous_velocity;
  logic [TIME_W-1:0]        previous_time;

  // per-word working registers
  logic [TIME_W-1:0] dt;
  logic              keep;
  logic              ang_neg;
  logic              vel_neg;
  logic              rpm_neg;

  logic in_accept;
  logic out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // glitch filter, evaluated on the accept cycle
  logic [COUNT_W:0]   th13;
  logic [COUNT_W:0]   hi13;
  logic [COUNT_W-1:0] prev_n;
  logic [COUNT_W-1:0] cur_n;
  logic [COUNT_W-1:0] jump;
  logic               reject;
  logic               wrap;
  logic [TIME_W-1:0]  dt_n;
  logic [COUNT_W-1:0] ang_mag_in;

  always_comb begin
    th13   = {1'b0, jump_threshold};
    hi13   = (COUNT_W+1)'(1 << COUNT_W) - th13;
    // the word after a rejection goes through unchecked and keeps the old reference
    prev_n = noise_seen ? previous_count : current_count;
    jump   = (raw_count >= prev_n) ? (raw_count - prev_n) : (prev_n - raw_count);
    reject = !noise_seen && ({1'b0, prev_n} > th13) && ({1'b0, prev_n} < hi13) &&
             ({1'b0, jump} > th13);
    cur_n  = reject ? prev_n : raw_count;
    // crossing the wrap zone in either direction holds the old velocity
    wrap   = (({1'b0, cur_n} < th13) && ({1'b0, prev_n} > hi13)) ||
             (({1'b0, cur_n} > hi13) && ({1'b0, prev_n} < th13));
    dt_n   = time_ms - previous_time;
    // |count - 2048|, at most 2048
    ang_mag_in = cur_n[COUNT_W-1] ? {1'b0, cur_n[COUNT_W-2:0]}
                                  : (COUNT_W'(1 << (COUNT_W-1)) - cur_n);
  end

  // shared digit-serial multiplier
  eavf_stat_t         mul_stat;
  logic               mul_start;
  logic [OPND_W-1:0]  mul_opnd;
  logic [K_W-1:0]     mul_k;
  logic [MUL_CNT_W-1:0] mul_digits;
  logic [PROD_W-1:0]  prod;

  // bit-serial divider
  eavf_stat_t        div_stat;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [NUM_W-1:0]  quo;

  // angle: round half away from zero of |centered| * pi / 2^24
  logic [PROD_W-1:0]          ang_sum;
  logic signed [ANGLE_W-1:0]  angle_next;
  logic signed [ANGLE_W:0]    delta;
  logic [ANGLE_W:0]           delta_mag;
  logic [ANGLE_W-1:0]         dmag;

  always_comb begin
    ang_sum    = prod + PROD_W'(1 << 23);
    angle_next = ang_neg ? -$signed({1'b0, ang_sum[ANGLE_W+22:24]})
                         : $signed({1'b0, ang_sum[ANGLE_W+22:24]});
    delta      = $signed({angle_next[ANGLE_W-1], angle_next}) -
                 $signed({previous_angle[ANGLE_W-1], previous_angle});
    delta_mag  = delta[ANGLE_W] ? (ANGLE_W+1)'(-delta) : delta;
    dmag       = delta_mag[ANGLE_W-1:0];
    // times 1000 = 1024 - 16 - 8
    div_num    = {dmag, 10'b0} - NUM_W'({dmag, 4'b0}) - NUM_W'({dmag, 3'b0});
  end

  // velocity select and magnitude for the rpm pass
  logic signed [VEL_W-1:0] vel_next;
  logic [VEL_W-1:0]        vel_mag;

  always_comb begin
    // quotient stays below 2^29, so no clipping is needed here
    if (keep) begin
      vel_next = previous_velocity;
    end else if (vel_neg) begin
      vel_next = -$signed(VEL_W'(quo));
    end else begin
      vel_next = $signed(VEL_W'(quo));
    end
    vel_mag = vel_next[VEL_W-1] ? VEL_W'(-vel_next) : VEL_W'(vel_next);
  end

  always_comb begin
    mul_start  = in_accept || (state == ST_DIV && div_stat.done);
    mul_opnd   = (state == ST_IDLE) ? {ang_mag_in, (OPND_W-COUNT_W)'(0)} : vel_mag;
    mul_k      = (state == ST_IDLE) ? PI_Q29 : RPM_Q24;
    mul_digits = (state == ST_IDLE) ? ANG_DIGITS : RPM_DIGITS;
    div_start  = (state == ST_ANG) && mul_stat.done;
  end

  // rpm: round half away from zero of |vel| * 30/pi / 2^32, then clip
  logic [PROD_W-1:0]       rpm_sum;
  logic [RPM_W-1:0]        rpm_mag;
  logic signed [RPM_W-1:0] rpm_sat;

  always_comb begin
    rpm_sum = prod + PROD_W'(1 << 31);
    rpm_mag = rpm_sum[PROD_W-1:PROD_W-RPM_W];
    if (rpm_neg) begin
      rpm_sat = (rpm_mag > RPM_W'(1 << (RPM_W-1))) ? $signed(RPM_W'(1 << (RPM_W-1)))
                                                   : -$signed(rpm_mag);
    end else begin
      rpm_sat = rpm_mag[RPM_W-1] ? $signed({1'b0, {(RPM_W-1){1'b1}}})
                                 : $signed(rpm_mag);
    end
  end

  eavf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mul_opnd),
    .k       (mul_k),
    .digits  (mul_digits),
    .stat    (mul_stat),
    .prod    (prod)
  );

  eavf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dt),
    .stat  (div_stat),
    .quo   (quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold     <= THRESHOLD_RESET;
      direction_negative <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: jump_threshold     <= cfg_data[TH_W-1:0];
        REG_DIRECTION: direction_negative <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      current_count     <= '0;
      previous_count    <= '0;
      noise_seen        <= 1'b0;
      previous_angle    <= '0;
      previous_velocity <= '0;
      previous_time     <= '0;
    end else begin
      // the final step reloads the output word itself
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            current_count  <= cur_n;
            previous_count <= prev_n;
            noise_seen     <= reject;
            previous_time  <= time_ms;
            dt             <= dt_n;
            keep           <= wrap || (dt_n == '0);
            // negative below mid count, flipped by direction
            ang_neg        <= !cur_n[COUNT_W-1] ^ direction_negative;
            state          <= ST_ANG;
          end
        end
        ST_ANG: begin
          if (mul_stat.done) begin
            previous_angle <= angle_next;
            vel_neg        <= delta[ANGLE_W];
            state          <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            previous_velocity <= vel_next;
            rpm_neg           <= vel_next[VEL_W-1];
            state             <= ST_RPM;
          end
        end
        ST_RPM: begin
          if (mul_stat.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            filtered_count <= current_count;
            angle_rad      <= previous_angle;
            velocity_rad_s <= previous_velocity;
            speed_rpm      <= rpm_sat;
            glitch_flag    <= noise_seen;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // arithmetic units are quiet whenever a new word can be taken
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mul_stat.busy && !div_stat.busy)
    else $error("arithmetic unit busy while idle");

  // multiplier and divider never run at the same time
  a_units_excl: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider overlap");

  // a word right after a rejection is never rejected
  a_no_double_reject: assert property (@(posedge clk) disable iff (rst)
    in_accept && noise_seen |=> !noise_seen)
    else $error("two rejections in a row");

  // a result word only appears out of the final step
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("output valid raised outside final step");

endmodule

// ----- tb/tb.sv -----
module tb;
  import eavf_pkg::*;

  // one expected output word, fields at the block's widths
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [ANGLE_W-1:0] angle;
    logic [VEL_W-1:0]   vel;
    logic [RPM_W-1:0]   rpm;
    logic               glitch;
  } angle_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [COUNT_W-1:0]       raw_count = '0;
  logic [TIME_W-1:0]        time_ms = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [COUNT_W-1:0]       filtered_count;
  logic signed [ANGLE_W-1:0] angle_rad;
  logic signed [VEL_W-1:0]  velocity_rad_s;
  logic signed [RPM_W-1:0]  speed_rpm;
  logic                     glitch_flag;

  encoder_angle_velocity_filter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .raw_count      (raw_count),
    .time_ms        (time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_count (filtered_count),
    .angle_rad      (angle_rad),
    .velocity_rad_s (velocity_rad_s),
    .speed_rpm      (speed_rpm),
    .glitch_flag    (glitch_flag)
  );

  // filter state as the predictor sees it, plus its copy of the registers
  logic [TH_W-1:0]    model_threshold = THRESHOLD_RESET;
  logic               model_dir_neg = 1'b0;
  logic [COUNT_W-1:0] model_cur = '0;
  logic [COUNT_W-1:0] model_prev = '0;
  logic               model_noise = 1'b0;
  longint             model_prev_angle = 0;
  longint             model_prev_vel = 0;
  logic [TIME_W-1:0]  model_prev_time = '0;

  // words predicted at input accept, waiting for the block's output
  angle_word_t expected_words[$];
  int error_count = 0;
  int checked_words = 0;

  // idling knobs: each side draws a random idle gap per word, from zero up to its max
  int feed_gap_max = 19;
  int sink_stall_max = 19;
  // long receiver hold-off, served and then cleared by the receiver process
  int hold_cycles = 0;

  // stimulus trackers: sample clock and the smooth angle walk
  logic [TIME_W-1:0]  clock_ms = '0;
  logic [COUNT_W-1:0] walk_count = 12'd2048;

  initial begin
    forever #5 clk = ~clk;
  end

  // rounds the magnitude half up, then restores the sign
  function automatic longint round_off_shift(longint v, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // glitch filter, angle, velocity and rpm for one accepted sample
  function automatic angle_word_t predict_angle_word(logic [COUNT_W-1:0] raw,
                                                     logic [TIME_W-1:0] now);
    angle_word_t w;
    int th, hi, cur, prv, jump;
    longint ang, vel, rpm;
    logic [TIME_W-1:0] dt;
    th = int'(model_threshold);
    hi = 4096 - th;
    // previous count stays frozen on the step right after a rejection
    if (!model_noise) model_prev = model_cur;
    model_cur = raw;
    if (model_noise) begin
      // sample after a rejection goes through unchecked
      model_noise = 1'b0;
    end else if (int'(model_prev) > th && int'(model_prev) < hi) begin
      jump = int'(raw) - int'(model_prev);
      if (jump > th || jump < -th) begin
        model_cur = model_prev;
        model_noise = 1'b1;
      end
    end
    ang = round_off_shift((longint'(model_cur) - 2048) * longint'(PI_Q29), 24);
    if (model_dir_neg) ang = -ang;
    // elapsed time wraps modulo 2^32
    dt = now - model_prev_time;
    cur = int'(model_cur);
    prv = int'(model_prev);
    if ((cur < th && prv > hi) || (cur > hi && prv < th) || dt == '0) begin
      vel = model_prev_vel;
    end else begin
      vel = clamp32((ang - model_prev_angle) * 1000 / longint'({32'd0, dt}));
    end
    rpm = clamp32(round_off_shift(vel * longint'(RPM_Q24), 32));
    model_prev_time = now;
    model_prev_angle = ang;
    model_prev_vel = vel;
    w.count = model_cur;
    w.angle = ang[ANGLE_W-1:0];
    w.vel = vel[VEL_W-1:0];
    w.rpm = rpm[RPM_W-1:0];
    w.glitch = model_noise;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at output word %0d: %s", checked_words, msg);
    error_count++;
  endtask

  // predict on every input word the block takes
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_words.push_back(predict_angle_word(raw_count, time_ms));
  end

  // compare each output word against the oldest prediction
  always @(posedge clk) begin : check_output_words
    angle_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected, count %0d",
                                  filtered_count));
      end else begin
        want = expected_words.pop_front();
        if (filtered_count !== want.count)
          report_mismatch($sformatf("filtered_count exp %0d got %0d",
                                    want.count, filtered_count));
        if (angle_rad !== want.angle)
          report_mismatch($sformatf("angle_rad exp %0d got %0d",
                                    $signed(want.angle), angle_rad));
        if (velocity_rad_s !== want.vel)
          report_mismatch($sformatf("velocity_rad_s exp %0d got %0d",
                                    $signed(want.vel), velocity_rad_s));
        if (speed_rpm !== want.rpm)
          report_mismatch($sformatf("speed_rpm exp %0d got %0d",
                                    $signed(want.rpm), speed_rpm));
        if (glitch_flag !== want.glitch)
          report_mismatch($sformatf("glitch_flag exp %0b got %0b",
                                    want.glitch, glitch_flag));
      end
      checked_words++;
    end
  end

  // receiver: random stall per word, plus the long hold-off on request
  initial begin : drain_output_words
    int wait_n;
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      wait_n = $urandom_range(0, sink_stall_max);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_cycles == 0);
    end
  end

  // offer one sample word; valid stays high on return so a back-to-back
  // word never drops it in between
  task automatic send_sample(logic [COUNT_W-1:0] c, logic [TIME_W-1:0] t);
    int gap;
    gap = $urandom_range(0, feed_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_count <= c;
    time_ms   <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_after(logic [COUNT_W-1:0] c, int step_ms);
    clock_ms += step_ms;
    send_sample(c, clock_ms);
  endtask

  // drop valid, let the last accept land, then wait for every result
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_register(logic [CFG_IDX_W-1:0] idx,
                                logic [CFG_DATA_W-1:0] val);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) model_threshold = val;
    else model_dir_neg = val[0];
  endtask

  // count and time extremes straight after reset
  task automatic test_count_extremes();
    send_sample(12'd0, 32'd0);             // zero elapsed time from reset
    send_sample(12'd4095, 32'd1);          // top of range, wrap crossing up
    send_sample(12'd2048, 32'd2);          // angle zero
    send_sample(12'd2047, 32'd3);
    send_sample(12'd4095, 32'hFFFF_FFFF);  // big jump rejected, huge elapsed
    send_sample(12'd0, 32'd5);             // unchecked after reject, time wraps
    send_sample(12'd2048, 32'd5);          // zero elapsed, velocity held
    clock_ms = 32'd5;
  endtask

  // jump exactly at threshold passes, one more is rejected
  task automatic test_glitch_filter();
    send_after(12'd2000, 10);
    send_after(12'd2256, 10);   // jump equal to threshold
    send_after(12'd2513, 10);   // jump over threshold
    send_after(12'd100, 10);    // accepted unchecked
    send_after(12'd1500, 1);    // previous in wrap zone, no check
    send_after(12'd1243, 1);    // downward jump over threshold
    send_after(12'd1300, 0);    // unchecked, same millisecond
    send_after(12'd1301, 3);
  endtask

  // crossings of the 0/4095 seam keep the old velocity
  task automatic test_wrap_crossing();
    send_after(12'd4000, 5);
    send_after(12'd4090, 5);
    send_after(12'd10, 5);
    send_after(12'd4080, 7);
  endtask

  // overlapping wrap zones, then zero threshold
  task automatic test_large_threshold();
    write_register(REG_THRESHOLD, 12'd3000);
    send_after(12'd2048, 4);
    send_after(12'd100, 4);
    send_after(12'd3900, 4);
    write_register(REG_THRESHOLD, 12'd0);
    send_after(12'd2048, 4);
    send_after(12'd2049, 4);    // any move at all is a jump
    send_after(12'd4000, 4);
    write_register(REG_THRESHOLD, THRESHOLD_RESET);
  endtask

  // receiver holds off for a long stretch while words keep coming, so the
  // block fills up and must stall its input
  task automatic test_backpressure();
    feed_gap_max = 0;
    hold_cycles = 400;
    for (int n = 0; n < 16; n++) begin
      walk_count = COUNT_W'(int'(walk_count) + $urandom_range(0, 40) - 20);
      send_after(walk_count, 10);
    end
    wait_until_drained();
    feed_gap_max = 19;
  endtask

  // mostly smooth motion with random content, plus jumps, seam visits and noise
  task automatic test_random_phases();
    int th_list[7] = '{256, 0, 2048, 1, -1, -1, 3000};
    int dir_list[7] = '{0, 1, 0, 1, -1, -1, 1};
    int gap_list[7] = '{19, 0, 19, 0, 19, 19, 19};
    int stall_list[7] = '{19, 0, 0, 19, 19, 19, 19};
    int th, dir, sel, span;
    logic [COUNT_W-1:0] c;
    for (int p = 0; p < 7; p++) begin
      th = (th_list[p] < 0) ? $urandom_range(2, 2047) : th_list[p];
      dir = (dir_list[p] < 0) ? $urandom_range(0, 1) : dir_list[p];
      write_register(REG_THRESHOLD, CFG_DATA_W'(th));
      write_register(REG_DIRECTION, CFG_DATA_W'(dir));
      feed_gap_max = gap_list[p];
      sink_stall_max = stall_list[p];
      span = (th > 2000) ? 2047 : th + th / 4 + 4;
      for (int n = 0; n < 160; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          // step around the threshold size
          walk_count = COUNT_W'(int'(walk_count) + $urandom_range(0, 2 * span) - span);
          c = walk_count;
        end else if (sel < 70) begin
          // land inside one of the wrap zones
          if ($urandom_range(0, 1))
            walk_count = COUNT_W'($urandom_range(0, th + 8));
          else
            walk_count = COUNT_W'(4095 - $urandom_range(0, th + 8));
          c = walk_count;
        end else if (sel < 85) begin
          // single spike, walk resumes afterwards
          c = COUNT_W'($urandom);
        end else begin
          walk_count = COUNT_W'($urandom);
          c = walk_count;
        end
        sel = $urandom_range(0, 99);
        if (sel >= 90) clock_ms = $urandom;
        else if (sel >= 25) clock_ms += $urandom_range(1, 30);
        else if (sel >= 10) clock_ms += $urandom_range(31, 5000);
        send_sample(c, clock_ms);
      end
    end
    feed_gap_max = 19;
    sink_stall_max = 19;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_count_extremes();
    test_glitch_filter();
    test_wrap_crossing();
    test_large_threshold();
    test_backpressure();
    test_random_phases();
    wait_until_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
